// ----- hw/rtl/sosc_pkg.sv -----
// ----------------------------------------------------------------------------
// sosc_pkg
// Shared types and constants of the shift outlier sigma clip unit.
// ----------------------------------------------------------------------------
package sosc_pkg;

  // reset value of the zone width register (3.0 in Q4.8)
  localparam logic [11:0] Z_RESET = 12'd768;
  localparam int Z_W = 12;
  // fewest inliers for the recomputed mean
  localparam int MIN_INLIERS = 4;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_NQ,
    OP_SS,
    OP_VDIV,
    OP_VSAVE,
    OP_ZONE,
    OP_MDIV,
    OP_MSAVE,
    OP_BOUNDS,
    OP_RD,
    OP_CHK,
    OP_IDIV,
    OP_ISAVE,
    OP_REP,
    OP_ORD,
    OP_OLD
  } op_t;

  // controller states
  typedef enum logic [4:0] {
    S_LOAD,
    S_NQ,
    S_SS,
    S_VDIV,
    S_VWAIT,
    S_VSAVE,
    S_SQWAIT,
    S_ZONE,
    S_MDIV,
    S_MWAIT,
    S_MSAVE,
    S_BOUNDS,
    S_RD,
    S_CHK,
    S_IDIV,
    S_IWAIT,
    S_ISAVE,
    S_REP,
    S_ORD,
    S_OLD
  } state_t;

  // datapath status back to the controller
  typedef struct packed {
    logic close;
    logic div_busy;
    logic sq_busy;
    logic ax;
    logic last_idx;
    logic out_free;
  } status_t;

endpackage

// ----- hw/rtl/sosc_ram.sv -----
// ----------------------------------------------------------------------------
// sosc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sosc_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/sosc_div.sv -----
// ----------------------------------------------------------------------------
// sosc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sosc_div #(
  parameter int NUM_W = 50,
  parameter int DEN_W = 14
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_r;
  logic [CW-1:0]    cnt_r;
  logic [NUM_W-1:0] q_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;

  assign trial = {rem_r, q_r[NUM_W-1]};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // shift and subtract step
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_r <= DEN_W'(trial - {1'b0, den_r});
        q_r   <= {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[DEN_W-1:0];
        q_r   <= {q_r[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign quo  = q_r;

endmodule

// ----- hw/rtl/sosc_ctrl.sv -----
// ----------------------------------------------------------------------------
// sosc_ctrl
// Sequencer: load, per-axis statistics, inlier pass, output pass.
// ----------------------------------------------------------------------------
module sosc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  sosc_pkg::status_t stat,
  output sosc_pkg::op_t     op
);

  import sosc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD:   if (stat.close) state_nxt = S_NQ;
      S_NQ:     state_nxt = S_SS;
      S_SS:     state_nxt = S_VDIV;
      S_VDIV:   state_nxt = S_VWAIT;
      S_VWAIT:  if (!stat.div_busy) state_nxt = S_VSAVE;
      S_VSAVE:  state_nxt = S_SQWAIT;
      S_SQWAIT: if (!stat.sq_busy) state_nxt = S_ZONE;
      S_ZONE:   state_nxt = S_MDIV;
      S_MDIV:   state_nxt = S_MWAIT;
      S_MWAIT:  if (!stat.div_busy) state_nxt = S_MSAVE;
      S_MSAVE:  state_nxt = S_BOUNDS;
      S_BOUNDS: state_nxt = stat.ax ? S_RD : S_NQ;
      S_RD:     state_nxt = S_CHK;
      S_CHK:    state_nxt = stat.last_idx ? S_IDIV : S_RD;
      S_IDIV:   state_nxt = S_IWAIT;
      S_IWAIT:  if (!stat.div_busy) state_nxt = S_ISAVE;
      S_ISAVE:  state_nxt = stat.ax ? S_REP : S_IDIV;
      S_REP:    state_nxt = S_ORD;
      S_ORD:    state_nxt = S_OLD;
      S_OLD: begin
        if (stat.out_free) begin
          state_nxt = stat.last_idx ? S_LOAD : S_ORD;
        end
      end
      default:  state_nxt = S_LOAD;
    endcase
  end

  // operation for the datapath
  always_comb begin
    case (state_r)
      S_LOAD:   op = OP_LOAD;
      S_NQ:     op = OP_NQ;
      S_SS:     op = OP_SS;
      S_VDIV:   op = OP_VDIV;
      S_VSAVE:  op = OP_VSAVE;
      S_ZONE:   op = OP_ZONE;
      S_MDIV:   op = OP_MDIV;
      S_MSAVE:  op = OP_MSAVE;
      S_BOUNDS: op = OP_BOUNDS;
      S_RD:     op = OP_RD;
      S_CHK:    op = OP_CHK;
      S_IDIV:   op = OP_IDIV;
      S_ISAVE:  op = OP_ISAVE;
      S_REP:    op = OP_REP;
      S_ORD:    op = OP_ORD;
      S_OLD:    op = stat.out_free ? OP_OLD : OP_NONE;
      default:  op = OP_NONE;
    endcase
  end

endmodule

// ----- hw/rtl/sosc_dp.sv -----
// ----------------------------------------------------------------------------
// sosc_dp
// Datapath: set store, sums, divider, square root, zone and replacement.
// ----------------------------------------------------------------------------
module sosc_dp #(
  parameter int MAX_ITEMS  = 64,
  parameter int SHIFT_BITS = 11,
  parameter int TD_W       = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sosc_pkg::op_t     op,
  output sosc_pkg::status_t stat,
  input  logic              cfg_wr_en,
  input  logic [11:0]       cfg_wr_data,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [TD_W-1:0]   in_tdata,
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [TD_W-1:0]   out_tdata,
  output logic              out_tuser,
  output logic              out_tlast
);

  import sosc_pkg::*;

  localparam int SB     = SHIFT_BITS;
  localparam int ADDR_W = $clog2(MAX_ITEMS);
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int SUM_W  = SB + ADDR_W;
  localparam int SQ_W   = 2 * SB - 1 + ADDR_W;
  localparam int NQ_W   = CNT_W + SQ_W;
  localparam int NUM_W  = NQ_W + 16;
  localparam int DEN_W  = 2 * CNT_W;
  localparam int VAR_W  = 2 * SB + 14;
  localparam int RT_W   = VAR_W / 2;
  localparam int ZONE_W = RT_W + Z_W;
  localparam int M_W    = SB + 9;
  localparam int T_W    = ZONE_W + 2;
  localparam int LB_W   = T_W - 16;

  // helpers
  function automatic logic [SUM_W-1:0] abs_s(input logic signed [SUM_W-1:0] v);
    return v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
  endfunction

  function automatic logic signed [M_W-1:0] to_m8(input logic [NUM_W-1:0] q,
                                                  input logic neg);
    logic signed [M_W-1:0] m;
    m = $signed({1'b0, q[M_W-2:0]});
    return neg ? -m : m;
  endfunction

  function automatic logic signed [LB_W-1:0] trunc16(input logic signed [T_W-1:0] v);
    logic [T_W-1:0] w;
    w = v + (v[T_W-1] ? T_W'(65535) : T_W'(0));
    return $signed(w[T_W-1:16]);
  endfunction

  function automatic logic [SB-1:0] trunc8(input logic signed [M_W-1:0] v);
    logic [M_W-1:0] w;
    w = v + (v[M_W-1] ? M_W'(255) : M_W'(0));
    return w[SB+7:8];
  endfunction

  // registers
  logic [Z_W-1:0]           z_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [ADDR_W-1:0]        idx_r;
  logic                     ax_r;
  logic signed [SUM_W-1:0]  sum_x_r, sum_y_r;
  logic [SQ_W-1:0]          sq_x_r, sq_y_r;
  logic [NQ_W-1:0]          nq_r;
  logic [NQ_W-1:0]          d_r;
  logic [DEN_W-1:0]         nn_r;
  logic [VAR_W-1:0]         sx_r, sr_r, sb_r;
  logic                     sq_busy_r;
  logic [ZONE_W-1:0]        zone_r;
  logic signed [M_W-1:0]    m8x_r, m8y_r;
  logic signed [LB_W-1:0]   lox_r, hix_r, loy_r, hiy_r;
  logic signed [SUM_W-1:0]  sx2_r, sy2_r;
  logic [CNT_W-1:0]         n2_r;
  logic [SB-1:0]            rx_r, ry_r;
  logic                     out_valid_r, out_valid_nxt;
  logic [SB-1:0]            ox_r, oy_r;
  logic                     orep_r, olast_r;

  // input side
  logic                     in_fire;
  logic signed [SB-1:0]     ia, ib;
  logic signed [2*SB-1:0]   ia2, ib2;

  assign in_tready = (op == OP_LOAD);
  assign in_fire   = in_tvalid && in_tready;
  assign ia        = $signed(in_tdata[SB-1:0]);
  assign ib        = $signed(in_tdata[2*SB-1:SB]);
  assign ia2       = ia * ia;
  assign ib2       = ib * ib;

  // stored item read back
  logic [2*SB-1:0]          rdata;
  logic signed [SB-1:0]     ra, rb;
  logic signed [LB_W-1:0]   rae, rbe;

  sosc_ram #(.WIDTH(2 * SB), .DEPTH(MAX_ITEMS)) u_store (
    .clk  (clk),
    .we   (in_fire),
    .waddr(cnt_r[ADDR_W-1:0]),
    .wdata({ib, ia}),
    .re   (op == OP_RD || op == OP_ORD),
    .raddr(idx_r),
    .rdata(rdata)
  );

  assign ra  = $signed(rdata[SB-1:0]);
  assign rb  = $signed(rdata[2*SB-1:SB]);
  assign rae = LB_W'(ra);
  assign rbe = LB_W'(rb);

  // per-axis selection
  logic signed [SUM_W-1:0]   s_sel, s2_sel;
  logic [SQ_W-1:0]           q_sel;
  logic signed [M_W-1:0]     m8_sel;
  logic [NQ_W-1:0]           nq_prod;
  logic signed [2*SUM_W-1:0] ss_prod;
  logic [DEN_W-1:0]          nn_prod;

  assign s_sel   = ax_r ? sum_y_r : sum_x_r;
  assign s2_sel  = ax_r ? sy2_r : sx2_r;
  assign q_sel   = ax_r ? sq_y_r : sq_x_r;
  assign m8_sel  = ax_r ? m8y_r : m8x_r;
  assign nq_prod = NQ_W'(cnt_r) * NQ_W'(q_sel);
  assign ss_prod = s_sel * s_sel;
  assign nn_prod = DEN_W'(cnt_r) * DEN_W'(cnt_r);

  // shared divider
  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_busy;
  logic [NUM_W-1:0] div_quo;

  always_comb begin
    div_start = 1'b0;
    div_num   = {d_r, 16'h0000};
    div_den   = nn_r;
    case (op)
      OP_VDIV: div_start = 1'b1;
      OP_MDIV: begin
        div_start = 1'b1;
        div_num   = NUM_W'({abs_s(s_sel), 8'h00});
        div_den   = DEN_W'(cnt_r);
      end
      OP_IDIV: begin
        div_start = 1'b1;
        div_num   = NUM_W'({abs_s(s2_sel), 8'h00});
        div_den   = DEN_W'(n2_r);
      end
      default: ;
    endcase
  end

  sosc_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .quo  (div_quo)
  );

  // zone bounds from mean and zone width
  logic signed [T_W-1:0]  t_mid, t_lo, t_hi;
  logic signed [LB_W-1:0] b_lo, b_hi;

  assign t_mid = T_W'(m8_sel) <<< 8;
  assign t_lo  = t_mid - $signed({2'b00, zone_r});
  assign t_hi  = t_mid + $signed({2'b00, zone_r});
  assign b_lo  = trunc16(t_lo);
  assign b_hi  = trunc16(t_hi);

  // inlier and outlier tests of the item read back
  logic inl, outl;

  assign inl  = (lox_r <= rae) && (rae < hix_r) && (loy_r <= rbe) && (rbe < hiy_r);
  assign outl = (rae < lox_r) || (rae > hix_r) || (rbe < loy_r) || (rbe > hiy_r);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z_r <= Z_RESET;
    end else if (cfg_wr_en) begin
      z_r <= cfg_wr_data;
    end
  end

  // set count and running sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
      sq_x_r  <= '0;
      sq_y_r  <= '0;
    end else if (in_fire) begin
      cnt_r   <= cnt_r + CNT_W'(1);
      sum_x_r <= sum_x_r + SUM_W'(ia);
      sum_y_r <= sum_y_r + SUM_W'(ib);
      sq_x_r  <= sq_x_r + SQ_W'($unsigned(ia2));
      sq_y_r  <= sq_y_r + SQ_W'($unsigned(ib2));
    end else if (op == OP_OLD && stat.last_idx) begin
      cnt_r   <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
      sq_x_r  <= '0;
      sq_y_r  <= '0;
    end
  end

  // axis select and item index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r  <= 1'b0;
      idx_r <= '0;
    end else begin
      case (op)
        OP_BOUNDS: begin
          ax_r  <= ~ax_r;
          idx_r <= '0;
        end
        OP_ISAVE: ax_r  <= ~ax_r;
        OP_REP:   idx_r <= '0;
        OP_CHK,
        OP_OLD:   idx_r <= idx_r + ADDR_W'(1);
        default: ;
      endcase
    end
  end

  // variance terms
  always_ff @(posedge clk) begin
    case (op)
      OP_NQ: nq_r <= nq_prod;
      OP_SS: begin
        d_r  <= nq_r - NQ_W'($unsigned(ss_prod));
        nn_r <= nn_prod;
      end
      OP_ZONE: zone_r <= ZONE_W'(sr_r[RT_W-1:0]) * ZONE_W'(z_r);
      default: ;
    endcase
  end

  // square root, one result bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
    end else if (op == OP_VSAVE) begin
      sq_busy_r <= 1'b1;
    end else if (sq_busy_r && sb_r == VAR_W'(1)) begin
      sq_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_VSAVE) begin
      sx_r <= div_quo[VAR_W-1:0];
      sr_r <= '0;
      sb_r <= VAR_W'(1) << (VAR_W - 2);
    end else if (sq_busy_r) begin
      if (sx_r >= sr_r + sb_r) begin
        sx_r <= sx_r - (sr_r + sb_r);
        sr_r <= (sr_r >> 1) + sb_r;
      end else begin
        sr_r <= sr_r >> 1;
      end
      sb_r <= sb_r >> 2;
    end
  end

  // means, bounds and replacement values
  always_ff @(posedge clk) begin
    case (op)
      OP_MSAVE: begin
        if (ax_r) m8y_r <= to_m8(div_quo, s_sel[SUM_W-1]);
        else      m8x_r <= to_m8(div_quo, s_sel[SUM_W-1]);
      end
      OP_BOUNDS: begin
        if (ax_r) begin
          loy_r <= b_lo;
          hiy_r <= b_hi;
        end else begin
          lox_r <= b_lo;
          hix_r <= b_hi;
        end
      end
      OP_ISAVE: begin
        if (n2_r >= CNT_W'(MIN_INLIERS)) begin
          if (ax_r) m8y_r <= to_m8(div_quo, s2_sel[SUM_W-1]);
          else      m8x_r <= to_m8(div_quo, s2_sel[SUM_W-1]);
        end
      end
      OP_REP: begin
        rx_r <= trunc8(m8x_r);
        ry_r <= trunc8(m8y_r);
      end
      default: ;
    endcase
  end

  // inlier sums
  always_ff @(posedge clk) begin
    if (op == OP_BOUNDS) begin
      sx2_r <= '0;
      sy2_r <= '0;
      n2_r  <= '0;
    end else if (op == OP_CHK && inl) begin
      sx2_r <= sx2_r + SUM_W'(ra);
      sy2_r <= sy2_r + SUM_W'(rb);
      n2_r  <= n2_r + CNT_W'(1);
    end
  end

  // output register
  assign out_valid_nxt = (out_valid_r && !out_tready) || (op == OP_OLD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_OLD) begin
      ox_r    <= outl ? rx_r : ra;
      oy_r    <= outl ? ry_r : rb;
      orep_r  <= outl;
      olast_r <= stat.last_idx;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TD_W'({oy_r, ox_r});
  assign out_tuser  = orep_r;
  assign out_tlast  = olast_r;

  // status
  assign stat.close    = in_fire && (in_tlast || cnt_r == CNT_W'(MAX_ITEMS - 1));
  assign stat.div_busy = div_busy;
  assign stat.sq_busy  = sq_busy_r;
  assign stat.ax       = ax_r;
  assign stat.last_idx = (CNT_W'(idx_r) == cnt_r - CNT_W'(1));
  assign stat.out_free = !out_valid_r || out_tready;

endmodule

// ----- hw/rtl/shift_outlier_sigma_clip_unit.sv -----
// ----------------------------------------------------------------------------
// shift_outlier_sigma_clip_unit
// Sigma-clipped mean of a set of block shifts, with outlier replacement.
// ----------------------------------------------------------------------------
// channel  direction  fields (low bit up)
// in_      slave      tdata: shift_x, shift_y ; tlast: set_end
// out_     master     tdata: adj_x, adj_y ; tuser: was_replaced ; tlast: run_end
// cfg_     write      wr_data: z_level
//
// items load at one per cycle; the set closes on tlast or when the store fills
// after close: per axis two divider runs and a square root, then an inlier
// scan that reads and checks each item in turn, two more divider runs, then
// the results, each item read back and then registered, waiting on a stalled output
// input is held off from set close until the last result is registered
// synchronous active-low reset; no clearing pass, the store is written first
// ----------------------------------------------------------------------------
module shift_outlier_sigma_clip_unit #(
  parameter int MAX_ITEMS  = 64,
  parameter int SHIFT_BITS = 11
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [11:0]                          cfg_wr_data, // z_level
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((2*SHIFT_BITS+7)/8)*8-1:0]    in_tdata,    // shift_x, shift_y
  input  logic                                 in_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((2*SHIFT_BITS+7)/8)*8-1:0]    out_tdata,   // adj_x, adj_y
  output logic                                 out_tuser,   // was_replaced
  output logic                                 out_tlast
);

  import sosc_pkg::*;

  localparam int TD_W = ((2 * SHIFT_BITS + 7) / 8) * 8;

  op_t     op;
  status_t stat;

  // sequencer
  sosc_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .op   (op)
  );

  // datapath
  sosc_dp #(
    .MAX_ITEMS (MAX_ITEMS),
    .SHIFT_BITS(SHIFT_BITS),
    .TD_W      (TD_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .stat       (stat),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // no loading while an iterative unit is still running
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!stat.div_busy && !stat.sq_busy))
    else $error("input accepted while divider or root busy");

  // the root unit starts only from the variance save step
  a_sqrt_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(stat.sq_busy) |-> $past(op) == OP_VSAVE)
    else $error("square root started outside variance save");

  // a set close moves the sequencer out of loading
  a_close_leave: assert property (@(posedge clk) disable iff (!rst_n)
    stat.close |=> !in_tready)
    else $error("still loading after set close");

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Streams sets of block shifts through the sigma clip unit and checks every
// adjusted shift against a behavioral predictor of the clipped mean.
// ----------------------------------------------------------------------------
module tb_top;
  import sosc_pkg::*;

  localparam int SB = 11;
  localparam int MAXN = 64;
  localparam int DW = ((2*SB+7)/8)*8;
  localparam int IDLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 600;

  typedef struct packed {
    logic signed [SB-1:0] sx;
    logic signed [SB-1:0] sy;
    logic                 last;
  } shift_t;

  typedef struct packed {
    logic signed [SB-1:0] ax;
    logic signed [SB-1:0] ay;
    logic                 repl;
    logic                 last;
  } adj_t;

  logic clk, rst_n;
  logic cfg_wr_en;
  logic [11:0] cfg_wr_data;
  logic in_tvalid, in_tready, in_tlast;
  logic [DW-1:0] in_tdata;
  logic out_tvalid, out_tready, out_tuser, out_tlast;
  logic [DW-1:0] out_tdata;

  shift_outlier_sigma_clip_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // predictor state
  logic [11:0] zone_width;
  longint set_x[$];
  longint set_y[$];
  adj_t adj_expected[$];
  shift_t shift_pending[$];
  int errors;
  int idle_cycles;
  bit hold_in;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint isqrt(input longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // mean (q.8) and truncated zone bounds of one axis
  task automatic axis_zone(input longint vals[$], output longint m8, output longint lo,
                           output longint hi);
    longint n, s, q, d, s8, zone;
    n = vals.size();
    s = 0;
    q = 0;
    foreach (vals[i]) begin
      s += vals[i];
      q += vals[i] * vals[i];
    end
    d = n * q - s * s;
    if (d < 0) d = 0;
    m8 = (s * 256) / n;
    s8 = isqrt((d * 65536) / (n * n));
    zone = s8 * zone_width;
    lo = (m8 * 256 - zone) / 65536;
    hi = (m8 * 256 + zone) / 65536;
  endtask

  // close the collected set and queue its adjusted shifts
  task automatic clip_set();
    longint mx, my, lx, hx, ly, hy, sx2, sy2, n2, rx, ry;
    bit outl;
    adj_t r;
    axis_zone(set_x, mx, lx, hx);
    axis_zone(set_y, my, ly, hy);
    sx2 = 0;
    sy2 = 0;
    n2 = 0;
    foreach (set_x[i])
      if (lx <= set_x[i] && set_x[i] < hx && ly <= set_y[i] && set_y[i] < hy) begin
        sx2 += set_x[i];
        sy2 += set_y[i];
        n2++;
      end
    if (n2 >= MIN_INLIERS) begin
      mx = (sx2 * 256) / n2;
      my = (sy2 * 256) / n2;
    end
    rx = mx / 256;
    ry = my / 256;
    foreach (set_x[i]) begin
      outl = set_x[i] < lx || set_x[i] > hx || set_y[i] < ly || set_y[i] > hy;
      r.ax = outl ? rx[SB-1:0] : set_x[i][SB-1:0];
      r.ay = outl ? ry[SB-1:0] : set_y[i][SB-1:0];
      r.repl = outl;
      r.last = (i == set_x.size() - 1);
      adj_expected.push_back(r);
    end
    set_x.delete();
    set_y.delete();
  endtask

  task automatic predict_shift(input shift_t t);
    set_x.push_back(longint'(t.sx));
    set_y.push_back(longint'(t.sy));
    if (t.last || set_x.size() == MAXN) clip_set();
  endtask

  function automatic shift_t rand_shift(input int spread, input int center_x,
                                        input int center_y, input bit last);
    shift_t t;
    int vx, vy;
    vx = center_x + $urandom_range(2 * spread) - spread;
    vy = center_y + $urandom_range(2 * spread) - spread;
    if (vx > 1023) vx = 1023;
    if (vx < -1024) vx = -1024;
    if (vy > 1023) vy = 1023;
    if (vy < -1024) vy = -1024;
    t.sx = vx;
    t.sy = vy;
    t.last = last;
    return t;
  endfunction

  function automatic shift_t mk(input int vx, input int vy, input bit last);
    shift_t t;
    t.sx = vx;
    t.sy = vy;
    t.last = last;
    return t;
  endfunction

  // driver
  int in_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tlast <= 1'b0;
      in_gap <= 0;
    end else if (in_tvalid && !in_tready) begin
      // hold the transaction
    end else if (in_gap > 0) begin
      in_tvalid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (shift_pending.size() > 0 && !(hold_in && set_x.size() == 0)) begin
      shift_t t;
      t = shift_pending.pop_front();
      predict_shift(t);
      in_tvalid <= 1'b1;
      in_tdata <= DW'({t.sy, t.sx});
      in_tlast <= t.last;
      in_gap <= ($urandom_range(9) < 6) ? 0 :
                ($urandom_range(9) < 8) ? $urandom_range(3) : $urandom_range(40);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // monitor and receiver stalls
  int out_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap <= 0;
      idle_cycles <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        adj_t want;
        if (adj_expected.size() == 0) begin
          $display("unexpected result transaction at %0t", $realtime);
          errors++;
        end else begin
          want = adj_expected.pop_front();
          if ($signed(out_tdata[SB-1:0]) != want.ax)
            report("adj_x", $signed(out_tdata[SB-1:0]), want.ax);
          if ($signed(out_tdata[2*SB-1:SB]) != want.ay)
            report("adj_y", $signed(out_tdata[2*SB-1:SB]), want.ay);
          if (out_tuser != want.repl) report("was_replaced", out_tuser, want.repl);
          if (out_tlast != want.last) report("run_end", out_tlast, want.last);
        end
      end
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_gap > 0) begin
        out_tready <= 1'b0;
        out_gap <= out_gap - 1;
      end else if ($urandom_range(9) < 7) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        out_gap <= ($urandom_range(9) < 8) ? $urandom_range(3) : $urandom_range(30);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n && idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic wait_idle();
    while (shift_pending.size() > 0 || adj_expected.size() > 0 || set_x.size() > 0
           || in_tvalid)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_zone(input logic [11:0] z);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= z;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    zone_width = z;
  endtask

  // one set of shifts: a cluster, usually tight, with a few wild points
  task automatic queue_set(input int n);
    int cx, cy, spread;
    cx = $urandom_range(1600) - 800;
    cy = $urandom_range(1600) - 800;
    spread = ($urandom_range(3) == 0) ? $urandom_range(200) : $urandom_range(8);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        shift_pending.push_back(rand_shift(1024, 0, 0, i == n - 1));
      else
        shift_pending.push_back(rand_shift(spread, cx, cy, i == n - 1));
    end
  endtask

  initial begin
    logic [11:0] zones[5];
    int items;
    errors = 0;
    hold_in = 0;
    zone_width = Z_RESET;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: single item, field extremes, value on the upper bound,
    // fewer than four inliers, clear outliers
    shift_pending.push_back(mk(-1024, 1023, 1));
    shift_pending.push_back(mk(1023, -1024, 0));
    shift_pending.push_back(mk(-1024, 1023, 1));
    shift_pending.push_back(mk(0, 0, 0));
    shift_pending.push_back(mk(0, 0, 0));
    shift_pending.push_back(mk(10, 10, 1));
    for (int i = 0; i < 8; i++) shift_pending.push_back(mk(5 + i % 2, -3, 0));
    shift_pending.push_back(mk(900, -900, 0));
    shift_pending.push_back(mk(-7, 1000, 1));
    shift_pending.push_back(mk(682, 682, 0));
    shift_pending.push_back(mk(-683, -683, 1));
    wait_idle();

    // store full: closes without tlast
    for (int i = 0; i < MAXN; i++)
      shift_pending.push_back(rand_shift(20, 100, -100, 0));
    wait_idle();

    // random sets across zone widths, extremes included
    zones = '{12'd0, 12'd4095, 12'd256, 12'd512, 12'd768};
    items = 0;
    foreach (zones[k]) begin
      write_zone(zones[k]);
      for (int s = 0; s < 6; s++) begin
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(MAXN, 40) : $urandom_range(12, 1);
        queue_set(n);
        items += n;
      end
      // hold the sender at a set boundary until the unit drains once per phase
      repeat (40) @(posedge clk);
      hold_in = 1;
      while (adj_expected.size() > 0 || set_x.size() > 0 || in_tvalid) @(posedge clk);
      hold_in = 0;
      wait_idle();
    end
    while (items < 380) begin
      int n;
      n = $urandom_range(12, 1);
      queue_set(n);
      items += n;
    end
    // bit noise on one set of ten items
    for (int i = 0; i < 10; i++)
      shift_pending.push_back(mk($urandom_range(2047) - 1024, $urandom_range(2047) - 1024,
                                 i == 9));
    wait_idle();

    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/sosc_pkg.sv
hw/rtl/sosc_ram.sv
hw/rtl/sosc_div.sv
hw/rtl/sosc_ctrl.sv
hw/rtl/sosc_dp.sv
hw/rtl/shift_outlier_sigma_clip_unit.sv
tb/tb_top.sv
